// ===== design/rqs_pkg.sv =====
// Shared types and constants for the ready queue scheduler.
// Used by the channel interfaces, the queue cell and the top level.
package rqs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int COUNT_BITS  = 10;
  localparam int PID_W       = 8;
  localparam int SLICE_W     = 6;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = 2;

  localparam logic [SLICE_W-1:0] TIME_SLICE_RESET = SLICE_W'(2);
  localparam logic [SLICE_W-1:0] BUDGET_AGING     = SLICE_W'(1);
  localparam logic [SLICE_W-1:0] BUDGET_RUN       = '0;

  typedef enum logic [1:0] {
    ACT_ADMIT      = 2'd0,
    ACT_DISPATCH   = 2'd1,
    ACT_RETURN     = 2'd2,
    ACT_ADMIT_HEAD = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SJF   = 2'd1,
    POL_AGING = 2'd2,
    POL_RR    = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_FINISHED = 2'd3
  } status_t;

  localparam logic [IDX_W-1:0] REG_POLICY     = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_TIME_SLICE = IDX_W'(1);

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_AGE  = 2'd1,
    CELL_PUSH = 2'd2,
    CELL_POP  = 2'd3
  } cell_op_t;

  // Which entries an insert passes over.
  typedef enum logic [1:0] {
    KEY_NONE  = 2'd0,   // passes nothing: head
    KEY_ALL   = 2'd1,   // passes every valid entry: tail
    KEY_LEN   = 2'd2,   // passes length <= key
    KEY_SCORE = 2'd3    // passes score <= key
  } key_sel_t;

  typedef struct packed {
    logic [PID_W-1:0]      pid;
    logic [COUNT_BITS-1:0] length;
    logic [COUNT_BITS-1:0] pc;
    logic [COUNT_BITS-1:0] score;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } cell_link_t;

  typedef struct packed {
    cell_op_t              op;
    key_sel_t              key_sel;
    logic [COUNT_BITS-1:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    action_t               action;
    entry_t                data;
    logic                  fault;
  } req_t;

  typedef struct packed {
    status_t               status;
    entry_t                data;
    logic [SLICE_W-1:0]    budget;
    logic [CNT_W-1:0]      occupancy;
  } res_t;

endpackage

// ===== design/rqs_in_if.sv =====
// Request channel: valid/ready handshake with one scheduling request.
// Depends on rqs_pkg.
interface rqs_in_if import rqs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [PID_W-1:0]      pid;
  logic [COUNT_BITS-1:0] length;
  logic [COUNT_BITS-1:0] pc;
  logic [COUNT_BITS-1:0] score;
  logic                  fault;

  modport source (output valid, action, pid, length, pc, score, fault, input ready);
  modport sink   (input valid, action, pid, length, pc, score, fault, output ready);
endinterface

// ===== design/rqs_out_if.sv =====
// Result channel: valid/ready handshake with one scheduling result.
// Depends on rqs_pkg.
interface rqs_out_if import rqs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [PID_W-1:0]      out_pid;
  logic [COUNT_BITS-1:0] out_length;
  logic [COUNT_BITS-1:0] out_pc;
  logic [COUNT_BITS-1:0] out_score;
  logic [SLICE_W-1:0]    slice_budget;
  logic [CNT_W-1:0]      occupancy;

  modport source (output valid, status, out_pid, out_length, out_pc, out_score,
                  slice_budget, occupancy, input ready);
  modport sink   (input valid, status, out_pid, out_length, out_pc, out_score,
                  slice_budget, occupancy, output ready);
endinterface

// ===== design/rqs_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on rqs_pkg.
interface rqs_cfg_if import rqs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   index;
  logic [SLICE_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ready_queue_scheduler_with_aging.sv =====
// Ready queue scheduler with aging: control FSM, registers and the cell row.
// Depends on rqs_pkg, rqs_in_if, rqs_out_if, rqs_cfg_if and rqs_cell.
//
//  channel | dir | handshake    | payload
//  in_ch   | in  | valid/ready  | action, pid, length, pc, score, fault
//  out_ch  | out | valid/ready  | status, out_pid, out_length, out_pc, out_score,
//          |     |              | slice_budget, occupancy
//  cfg     | in  | valid/ready  | index, data (ready always high)
//
// Admit, dispatch and non-aging returns go from the transfer straight to one
// shift pass through the cell row. An aging return goes through the transfer, an
// aging pass, a lower-score scan along the row, then the insert pass.
// Reset clears the queue count, the cell valid bits and the registers.
// The result sits in an output register; a new request is taken while it
// waits, and the insert pass holds until that register is free.
module ready_queue_scheduler_with_aging import rqs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rqs_in_if.sink    in_ch,
  rqs_out_if.source out_ch,
  rqs_cfg_if.sink   cfg
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_AGE   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t             state, state_next;
  policy_t            policy;
  logic [SLICE_W-1:0] time_slice;
  logic [CNT_W-1:0]   count, count_next;
  req_t               req;
  logic               lower;
  logic               out_valid;
  res_t               res, res_next;
  cell_ctrl_t         ctrl;
  logic               apply_go;

  cell_link_t             links [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]   pass_chain;
  logic [QUEUE_DEPTH:0]   lower_chain;
  logic [QUEUE_DEPTH-1:0] valid_vec;

  logic in_fire, full, aging, finished, in_aging_ret;

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg.ready   = 1'b1;
  assign full        = (count >= CNT_W'(QUEUE_DEPTH));
  assign aging       = (policy == POL_AGING);
  assign finished    = (req.data.pc >= req.data.length);

  // aging pass needed for a return under aging without fault, unless it is
  // dropped on a full queue
  assign in_aging_ret = (action_t'(in_ch.action) == ACT_RETURN) && (policy == POL_AGING)
                     && !in_ch.fault
                     && ((in_ch.pc >= in_ch.length) || (count < CNT_W'(QUEUE_DEPTH)));

  // ---- cell row ----
  assign pass_chain[0]  = 1'b1;
  assign lower_chain[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      cell_link_t left_link, right_link;
      if (g == 0) begin : g_head
        assign left_link = '0;
      end else begin : g_mid_l
        assign left_link = links[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign right_link = '0;
      end else begin : g_mid_r
        assign right_link = links[g+1];
      end
      rqs_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .new_entry (req.data),
        .left      (left_link),
        .right     (right_link),
        .pass_in   (pass_chain[g]),
        .lower_in  (lower_chain[g]),
        .pass_out  (pass_chain[g+1]),
        .lower_out (lower_chain[g+1]),
        .cur       (links[g])
      );
      assign valid_vec[g] = links[g].valid;
    end
  endgenerate

  // ---- control ----
  assign apply_go = !out_valid || out_ch.ready;

  always_comb begin
    state_next = state;
    count_next = count;
    ctrl       = '{op: CELL_HOLD, key_sel: KEY_NONE, key: req.data.score};
    res_next   = '0;
    res_next.status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_fire) state_next = in_aging_ret ? S_AGE : S_APPLY;
      end
      S_AGE: begin
        ctrl.op    = CELL_AGE;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        unique case (req.action)
          ACT_DISPATCH: begin
            if (count == '0) begin
              res_next.status = ST_EMPTY;
            end else begin
              ctrl.op       = CELL_POP;
              res_next.data = links[0].data;
              count_next    = count - CNT_W'(1);
              case (policy)
                POL_AGING: res_next.budget = BUDGET_AGING;
                POL_RR:    res_next.budget = time_slice;
                default:   res_next.budget = BUDGET_RUN;
              endcase
            end
          end
          ACT_ADMIT, ACT_ADMIT_HEAD: begin
            if (full) begin
              res_next.status = ST_FULL;
            end else begin
              ctrl.op    = CELL_PUSH;
              count_next = count + CNT_W'(1);
              if (req.action == ACT_ADMIT_HEAD) begin
                ctrl.key_sel = KEY_NONE;
              end else begin
                case (policy)
                  POL_SJF: begin
                    ctrl.key_sel = KEY_LEN;
                    ctrl.key     = req.data.length;
                  end
                  POL_AGING: ctrl.key_sel = KEY_SCORE;
                  default:   ctrl.key_sel = KEY_ALL;
                endcase
              end
            end
          end
          ACT_RETURN: begin
            if (finished) begin
              res_next.status = ST_FINISHED;
            end else if (full) begin
              res_next.status = ST_FULL;
            end else begin
              ctrl.op    = CELL_PUSH;
              count_next = count + CNT_W'(1);
              if (!aging)         ctrl.key_sel = KEY_ALL;
              else if (req.fault) ctrl.key_sel = KEY_SCORE;
              else                ctrl.key_sel = lower ? KEY_SCORE : KEY_NONE;
            end
          end
          default: ;
        endcase
        res_next.occupancy = count_next;
        if (!apply_go) begin
          ctrl.op    = CELL_HOLD;
          count_next = count;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      out_valid  <= 1'b0;
      policy     <= POL_FCFS;
      time_slice <= TIME_SLICE_RESET;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_APPLY && apply_go) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      if (cfg.valid) begin
        case (cfg.index)
          REG_POLICY:     policy     <= policy_t'(cfg.data[1:0]);
          REG_TIME_SLICE: time_slice <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req.action      <= action_t'(in_ch.action);
      req.data.pid    <= in_ch.pid;
      req.data.length <= in_ch.length;
      req.data.pc     <= in_ch.pc;
      req.data.score  <= in_ch.score;
      req.fault       <= in_ch.fault;
    end
    if (state == S_SCAN) lower <= lower_chain[QUEUE_DEPTH];
    if (state == S_APPLY && apply_go) res <= res_next;
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = res.status;
  assign out_ch.out_pid      = res.data.pid;
  assign out_ch.out_length   = res.data.length;
  assign out_ch.out_pc       = res.data.pc;
  assign out_ch.out_score    = res.data.score;
  assign out_ch.slice_budget = res.budget;
  assign out_ch.occupancy    = res.occupancy;

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("cell valid bits disagree with count");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    !valid_vec[0] |-> (count == '0))
    else $error("queue head empty with entries counted");

  a_result_occupancy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res.occupancy == count))
    else $error("pending result occupancy out of step with queue");

endmodule

// ===== design/rqs_cell.sv =====
// One slot of the ready queue: holds an entry, shifts toward either neighbor,
// ages its score and takes part in the insert-position and lower-score chains.
// Depends on rqs_pkg.
module rqs_cell import rqs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  cell_link_t left,
  input  cell_link_t right,
  input  logic       pass_in,
  input  logic       lower_in,
  output logic       pass_out,
  output logic       lower_out,
  output cell_link_t cur
);

  logic   valid;
  entry_t data;
  logic   pass_here;
  logic   take_new;
  logic   take_left;

  always_comb begin
    case (ctrl.key_sel)
      KEY_NONE:  pass_here = 1'b0;
      KEY_ALL:   pass_here = valid;
      KEY_LEN:   pass_here = valid && (data.length <= ctrl.key);
      KEY_SCORE: pass_here = valid && (data.score <= ctrl.key);
      default:   pass_here = 1'b0;
    endcase
  end

  // pass_in high: every cell ahead was passed over
  assign pass_out  = pass_in && pass_here;
  assign lower_out = lower_in || (valid && (data.score < ctrl.key));
  assign take_new  = pass_in && !pass_here;
  assign take_left = !pass_in;
  assign cur       = '{valid: valid, data: data};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_PUSH: begin
          if (take_new) valid <= 1'b1;
          else if (take_left) valid <= left.valid;
        end
        CELL_POP: valid <= right.valid;
        default:  valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_AGE: begin
        if (data.score != '0) data.score <= data.score - COUNT_BITS'(1);
      end
      CELL_PUSH: begin
        if (take_new) data <= new_entry;
        else if (take_left) data <= left.data;
      end
      CELL_POP: data <= right.data;
      default:  data <= data;
    endcase
  end

endmodule

// ===== bench/rqs_sched_checker.sv =====
// Scoreboard for the ready queue scheduler: keeps its own ready queue, predicts
// every result from the observed request and config transfers, and compares.
// Depends on rqs_pkg and the rqs_in_if, rqs_out_if and rqs_cfg_if interfaces.
module rqs_sched_checker import rqs_pkg::*; (
  input  logic clk,
  input  logic rst,
  rqs_in_if    in_ch,
  rqs_out_if   out_ch,
  rqs_cfg_if   cfg,
  output int   fail_count,
  output int   pending,
  output int   checked
);

  entry_t             ready_q[$];
  res_t               expected_q[$];
  policy_t            cur_policy;
  logic [SLICE_W-1:0] cur_slice;

  function automatic int pos_by_length(input logic [COUNT_BITS-1:0] len);
    int i;
    i = 0;
    while (i < ready_q.size() && ready_q[i].length <= len) i++;
    return i;
  endfunction

  function automatic int pos_by_score(input logic [COUNT_BITS-1:0] sc);
    int i;
    i = 0;
    while (i < ready_q.size() && ready_q[i].score <= sc) i++;
    return i;
  endfunction

  // Aging saturates at zero.
  function automatic void age_scores();
    foreach (ready_q[i])
      if (ready_q[i].score != '0) ready_q[i].score = ready_q[i].score - COUNT_BITS'(1);
  endfunction

  function automatic res_t schedule_step(input req_t r);
    res_t res;
    int   pos;
    bit   lower;
    bit   aging;
    res   = '0;
    aging = (cur_policy == POL_AGING);
    case (r.action)
      ACT_DISPATCH: begin
        if (ready_q.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = ready_q.pop_front();
          case (cur_policy)
            POL_AGING: res.budget = BUDGET_AGING;
            POL_RR:    res.budget = cur_slice;
            default:   res.budget = BUDGET_RUN;
          endcase
        end
      end
      ACT_ADMIT, ACT_ADMIT_HEAD: begin
        if (ready_q.size() >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (r.action == ACT_ADMIT_HEAD) pos = 0;
          else if (cur_policy == POL_SJF) pos = pos_by_length(r.data.length);
          else if (aging) pos = pos_by_score(r.data.score);
          else pos = ready_q.size();
          ready_q.insert(pos, r.data);
        end
      end
      default: begin
        // finished check wins over the full check
        if (r.data.pc >= r.data.length) begin
          if (aging && !r.fault) age_scores();
          res.status = ST_FINISHED;
        end else if (ready_q.size() >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else if (!aging) begin
          ready_q.push_back(r.data);
        end else if (r.fault) begin
          ready_q.insert(pos_by_score(r.data.score), r.data);
        end else begin
          age_scores();
          lower = 1'b0;
          foreach (ready_q[i])
            if (ready_q[i].score < r.data.score) lower = 1'b1;
          pos = lower ? pos_by_score(r.data.score) : 0;
          ready_q.insert(pos, r.data);
        end
      end
    endcase
    res.occupancy = CNT_W'(ready_q.size());
    return res;
  endfunction

  task automatic report(input string field, input logic [15:0] got, input logic [15:0] want);
    if (fail_count < 40)
      $display("[%0t] result %0d: %s is %0h, predicted %0h", $realtime, checked, field, got,
               want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    req_t r;
    res_t want;
    if (rst) begin
      ready_q.delete();
      expected_q.delete();
      cur_policy = POL_FCFS;
      cur_slice  = TIME_SLICE_RESET;
      fail_count = 0;
      checked    = 0;
    end else begin
      // results never leave in the cycle their request is taken, so compare first
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result status", 16'(out_ch.status), '0);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (out_ch.status !== want.status)
            report("status", 16'(out_ch.status), 16'(want.status));
          if (out_ch.out_pid !== want.data.pid)
            report("out_pid", 16'(out_ch.out_pid), 16'(want.data.pid));
          if (out_ch.out_length !== want.data.length)
            report("out_length", 16'(out_ch.out_length), 16'(want.data.length));
          if (out_ch.out_pc !== want.data.pc)
            report("out_pc", 16'(out_ch.out_pc), 16'(want.data.pc));
          if (out_ch.out_score !== want.data.score)
            report("out_score", 16'(out_ch.out_score), 16'(want.data.score));
          if (out_ch.slice_budget !== want.budget)
            report("slice_budget", 16'(out_ch.slice_budget), 16'(want.budget));
          if (out_ch.occupancy !== want.occupancy)
            report("occupancy", 16'(out_ch.occupancy), 16'(want.occupancy));
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_POLICY) cur_policy = policy_t'(cfg.data[1:0]);
        else if (cfg.index == REG_TIME_SLICE) cur_slice = cfg.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        r.action      = action_t'(in_ch.action);
        r.data.pid    = in_ch.pid;
        r.data.length = in_ch.length;
        r.data.pc     = in_ch.pc;
        r.data.score  = in_ch.score;
        r.fault       = in_ch.fault;
        expected_q.push_back(schedule_step(r));
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the scheduler bench: clock, reset, request and config stimulus,
// result back-pressure, watchdog and verdict.
// Depends on rqs_pkg, the channel interfaces, the scheduler and rqs_sched_checker.
module tb_top;
  import rqs_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int PHASES     = 16;
  localparam int PHASE_LEN  = 62;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rqs_in_if  in_ch ();
  rqs_out_if out_ch ();
  rqs_cfg_if cfg ();

  int fail_count;
  int pending;
  int checked;

  int sent     = 0;
  int settings = 0;
  int hold_len = 0;
  int idle_cycles = 0;
  bit in_calm  = 1'b0;
  bit out_calm = 1'b0;

  ready_queue_scheduler_with_aging u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  rqs_sched_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  // valid stays up after a transfer; the next call either keeps it or drops it
  task automatic offer(input action_t act, input logic [PID_W-1:0] pid,
                       input logic [COUNT_BITS-1:0] len, input logic [COUNT_BITS-1:0] pc,
                       input logic [COUNT_BITS-1:0] sc, input logic flt);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.pid    <= pid;
    in_ch.length <= len;
    in_ch.pc     <= pc;
    in_ch.score  <= sc;
    in_ch.fault  <= flt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SLICE_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // drain every outstanding result, then give the cell row time to finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input policy_t pol, input logic [SLICE_W-1:0] slice);
    settle();
    write_reg(REG_POLICY, SLICE_W'(pol));
    write_reg(REG_TIME_SLICE, slice);
    cfg.valid <= 1'b0;
    settings++;
  endtask

  // result side back-pressure, with the one long hold-off on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      stall = out_calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding", idle_cycles, pending);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int admit_w[3];
    int head_w[3];
    int ret_w[3];
    admit_w = '{55, 25, 10};
    head_w  = '{10, 5, 5};
    ret_w   = '{20, 35, 15};

    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_ADMIT;
    in_ch.pid    <= '0;
    in_ch.length <= '0;
    in_ch.pc     <= '0;
    in_ch.score  <= '0;
    in_ch.fault  <= 1'b0;
    cfg.valid    <= 1'b0;
    cfg.index    <= REG_POLICY;
    cfg.data     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: first come first served, slice of two
    offer(ACT_DISPATCH,   8'h00, 10'd0,    10'd0,  10'd0,    1'b0);
    offer(ACT_ADMIT,      8'hFF, 10'd1023, 10'd0,  10'd1023, 1'b1);
    offer(ACT_ADMIT,      8'h00, 10'd0,    10'd0,  10'd0,    1'b0);
    offer(ACT_ADMIT_HEAD, 8'h5A, 10'd100,  10'd50, 10'd7,    1'b0);
    offer(ACT_RETURN,     8'h11, 10'd40,   10'd40, 10'd9,    1'b0);
    offer(ACT_RETURN,     8'h22, 10'd40,   10'd39, 10'd9,    1'b1);
    offer(ACT_DISPATCH,   8'h00, 10'd0,    10'd0,  10'd0,    1'b0);
    offer(ACT_DISPATCH,   8'h00, 10'd0,    10'd0,  10'd0,    1'b0);

    // shortest job first, equal lengths queue behind each other
    set_mode(POL_SJF, 6'd63);
    offer(ACT_ADMIT,      8'h31, 10'd300,  10'd0,  10'd4,    1'b0);
    offer(ACT_ADMIT,      8'h32, 10'd300,  10'd1,  10'd4,    1'b0);
    offer(ACT_ADMIT,      8'h33, 10'd5,    10'd2,  10'd4,    1'b0);
    offer(ACT_ADMIT_HEAD, 8'h34, 10'd900,  10'd3,  10'd4,    1'b0);
    offer(ACT_DISPATCH,   8'h00, 10'd0,    10'd0,  10'd0,    1'b0);

    // aging: fault return skips aging, finished return still ages,
    // lowest score goes to the head, a high score is placed by score
    set_mode(POL_AGING, 6'd1);
    offer(ACT_ADMIT,      8'h41, 10'd20,   10'd0,  10'd3,    1'b0);
    offer(ACT_ADMIT,      8'h42, 10'd20,   10'd0,  10'd3,    1'b0);
    offer(ACT_RETURN,     8'h43, 10'd10,   10'd1,  10'd2,    1'b1);
    offer(ACT_RETURN,     8'h44, 10'd5,    10'd9,  10'd6,    1'b0);
    offer(ACT_RETURN,     8'h45, 10'd10,   10'd2,  10'd0,    1'b0);
    offer(ACT_RETURN,     8'h46, 10'd800,  10'd2,  10'd1023, 1'b0);
    offer(ACT_DISPATCH,   8'h00, 10'd0,    10'd0,  10'd0,    1'b0);

    // round robin with a zero slice, then the widest slice
    set_mode(POL_RR, 6'd0);
    offer(ACT_DISPATCH,   8'h00, 10'd0,    10'd0,  10'd0,    1'b0);
    offer(ACT_RETURN,     8'h51, 10'd64,   10'd8,  10'd5,    1'b1);
    set_mode(POL_RR, 6'd63);
    offer(ACT_DISPATCH,   8'h00, 10'd0,    10'd0,  10'd0,    1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      policy_t            pol;
      logic [SLICE_W-1:0] slice;
      int                 style;
      int                 w;
      action_t            act;
      logic [COUNT_BITS-1:0] len;
      logic [COUNT_BITS-1:0] pc;
      logic [COUNT_BITS-1:0] sc;
      pol = policy_t'((ph + ph / 4) % 4);
      case (ph % 4)
        0:       slice = 6'd1;
        1:       slice = 6'd63;
        default: slice = SLICE_W'($urandom_range(1, 63));
      endcase
      if (ph == 10) slice = '0;
      style = ph % 3;
      set_mode(pol, slice);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      // stall the result side long enough to back the request side up
      if (ph == 4) begin
        in_calm  = 1'b1;
        hold_len = 300;
      end
      for (int k = 0; k < PHASE_LEN; k++) begin
        w = $urandom_range(0, 99);
        if (w < admit_w[style]) act = ACT_ADMIT;
        else if (w < admit_w[style] + head_w[style]) act = ACT_ADMIT_HEAD;
        else if (w < admit_w[style] + head_w[style] + ret_w[style]) act = ACT_RETURN;
        else act = ACT_DISPATCH;
        // small lengths and scores make ties and drive scores down to zero
        len = ($urandom_range(0, 1) == 0) ? COUNT_BITS'($urandom_range(0, 15))
                                          : COUNT_BITS'($urandom_range(0, 1023));
        sc  = ($urandom_range(0, 1) == 0) ? COUNT_BITS'($urandom_range(0, 7))
                                          : COUNT_BITS'($urandom_range(0, 1023));
        if (act == ACT_RETURN && len != '0 && $urandom_range(0, 4) != 0)
          pc = COUNT_BITS'($urandom_range(0, len - 1));
        else if (act == ACT_RETURN)
          pc = COUNT_BITS'($urandom_range(len, 1023));
        else
          pc = COUNT_BITS'($urandom_range(0, 1023));
        offer(act, PID_W'($urandom_range(0, 255)), len, pc, sc,
              ($urandom_range(0, 9) < 3));
      end
    end

    in_calm  = 1'b0;
    out_calm = 1'b0;
    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d requests under %0d register settings, all four actions and policies",
             sent, settings);
    $display("%0d results compared against the predicted ready queue", checked);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
